### rtl/iul_pkg.sv
// Shared types and constants for the interval union length core.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package iul_pkg;

	// Field and datapath widths
	localparam int FIELD_W = 28;
	localparam int SEG_W   = 30;
	localparam int OPND_W  = 31;
	localparam int TOTAL_W = 29;
	localparam int ACC_W   = 30;

	// Saturation ceiling for the reported total
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	typedef logic signed [SEG_W-1:0] coord_t;

	// One stored segment: first and last covered point
	typedef struct packed {
		coord_t lo;
		coord_t hi;
	} seg_t;

	// Result of the shared subtract/compare unit
	typedef struct packed {
		logic signed [OPND_W-1:0] diff;
		logic                     neg;
		logic                     zero;
	} alu_res_t;

endpackage

`default_nettype wire

### rtl/iul_seg_mem.sv
// Segment store: one write port, one read port with registered read data.
// Depends on iul_pkg for the segment type.
`default_nettype none

module iul_seg_mem
	import iul_pkg::*;
#(
	parameter int DEPTH = 128,
	parameter int AW    = 7
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire seg_t          wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output seg_t               rd_data
);

	seg_t mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port; data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

### rtl/iul_alu.sv
// Shared subtract/compare unit used by both the insertion and the sweep steps.
// Depends on iul_pkg for operand and result types.
`default_nettype none

module iul_alu
	import iul_pkg::*;
(
	input  wire coord_t op_a,
	input  wire coord_t op_b,
	output alu_res_t    res
);

	logic signed [OPND_W-1:0] diff;

	// Sign-extend by one bit so the difference never wraps
	assign diff = {op_a[SEG_W-1], op_a} - {op_b[SEG_W-1], op_b};

	assign res.diff = diff;
	assign res.neg  = diff[OPND_W-1];
	assign res.zero = (diff == '0);

endmodule

`default_nettype wire

### rtl/interval_union_length_core.sv
// Each item is written into its slot after moving past every stored segment that sorts after it,
// comparing ends as well on equal starts; an item that arrives with the store full is dropped.
// A last item then starts a sweep over the stored segments and posts the result,
// the post waiting until the output register is free. One item is in work at a time.
// Result sits in an output register, so the next item loads while it waits to transfer.
// Reset clears the sequencer, segment count, overflow flag and output valid at once;
// store contents stay undefined and need no clearing pass.
`default_nettype none

module interval_union_length_core
	import iul_pkg::*;
#(
	parameter int MAX_SEGMENTS = 128
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [FIELD_W-1:0] anchor_pos,
	input  wire logic [FIELD_W-1:0] seg_len,
	input  wire logic               points_left,
	input  wire logic               last_item,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [TOTAL_W-1:0]      covered_total,
	output logic                    overflow
);

	localparam int AW = $clog2(MAX_SEGMENTS);
	localparam int CW = $clog2(MAX_SEGMENTS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_CS,
		ST_INS_CE,
		ST_SW_RD,
		ST_SW_CMP,
		ST_SW_CNT,
		ST_DONE
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      count_q;
	logic               ovf_q;
	logic               last_q;
	seg_t               new_q;
	logic [AW-1:0]      k_q;
	logic [CW-1:0]      j_q;
	coord_t             reach_q;
	logic               have_q;
	logic               clip_q;
	logic [ACC_W-1:0]   total_q;
	logic               out_valid_q;
	logic [TOTAL_W-1:0] covered_q;
	logic               overflow_q;

	seg_t          new_seg;
	logic [SEG_W-1:0] pos_x;
	logic [SEG_W-1:0] len_x;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	seg_t          wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	seg_t          rd_data;
	coord_t        alu_a;
	coord_t        alu_b;
	alu_res_t      alu_res;
	logic          out_free;

	// Segment bounds of the incoming item
	assign pos_x = {2'b00, anchor_pos};
	assign len_x = {2'b00, seg_len};

	always_comb begin
		if (points_left) begin
			new_seg.lo = pos_x + 1'b1 - len_x;
			new_seg.hi = pos_x;
		end else begin
			new_seg.lo = pos_x;
			new_seg.hi = pos_x + len_x - 1'b1;
		end
	end

	assign in_stall      = (state_q != ST_IDLE);
	assign out_valid     = out_valid_q;
	assign covered_total = covered_q;
	assign overflow      = overflow_q;
	assign out_free      = !out_valid_q || !out_stall;

	// Store port and shared unit operand steering
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = k_q;
		wr_data = new_q;
		rd_en   = 1'b0;
		rd_addr = j_q[AW-1:0];
		alu_a   = rd_data.lo;
		alu_b   = reach_q;
		case (state_q)
			ST_INS_RD: begin
				if (k_q == '0) begin
					wr_en = 1'b1;
				end else begin
					rd_en   = 1'b1;
					rd_addr = k_q - 1'b1;
				end
			end
			ST_INS_CS: begin
				alu_a = new_q.lo;
				alu_b = rd_data.lo;
				if (alu_res.neg) begin
					wr_en   = 1'b1;
					wr_data = rd_data;
				end else if (!alu_res.zero) begin
					wr_en = 1'b1;
				end
			end
			ST_INS_CE: begin
				alu_a = new_q.hi;
				alu_b = rd_data.hi;
				wr_en = 1'b1;
				if (alu_res.neg) begin
					wr_data = rd_data;
				end
			end
			ST_SW_RD: begin
				rd_en = (j_q != count_q);
			end
			ST_SW_CMP: begin
				alu_a = rd_data.lo;
				alu_b = reach_q;
			end
			ST_SW_CNT: begin
				alu_a = rd_data.hi;
				alu_b = clip_q ? reach_q : rd_data.lo;
			end
			default: begin
			end
		endcase
	end

	iul_seg_mem #(
		.DEPTH(MAX_SEGMENTS),
		.AW   (AW)
	) u_mem (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	iul_alu u_alu (
		.op_a(alu_a),
		.op_b(alu_b),
		.res (alu_res)
	);

	// Sequencer, sweep registers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			last_q      <= 1'b0;
			new_q       <= '0;
			k_q         <= '0;
			j_q         <= '0;
			reach_q     <= '0;
			have_q      <= 1'b0;
			clip_q      <= 1'b0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
			covered_q   <= '0;
			overflow_q  <= 1'b0;
		end else begin
			// result leaves on its transfer unless a new one is posted this cycle
			if (out_valid_q && !out_stall && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						new_q  <= new_seg;
						last_q <= last_item;
						k_q    <= count_q[AW-1:0];
						if (count_q == CW'(MAX_SEGMENTS)) begin
							ovf_q <= 1'b1;
							if (last_item) begin
								j_q     <= '0;
								total_q <= '0;
								have_q  <= 1'b0;
								state_q <= ST_SW_RD;
							end
						end else begin
							state_q <= ST_INS_RD;
						end
					end
				end
				ST_INS_RD: begin
					if (k_q == '0) begin
						count_q <= count_q + 1'b1;
						j_q     <= '0;
						total_q <= '0;
						have_q  <= 1'b0;
						state_q <= last_q ? ST_SW_RD : ST_IDLE;
					end else begin
						state_q <= ST_INS_CS;
					end
				end
				ST_INS_CS: begin
					if (alu_res.neg) begin
						k_q     <= k_q - 1'b1;
						state_q <= ST_INS_RD;
					end else if (alu_res.zero) begin
						state_q <= ST_INS_CE;
					end else begin
						count_q <= count_q + 1'b1;
						j_q     <= '0;
						total_q <= '0;
						have_q  <= 1'b0;
						state_q <= last_q ? ST_SW_RD : ST_IDLE;
					end
				end
				ST_INS_CE: begin
					if (alu_res.neg) begin
						k_q     <= k_q - 1'b1;
						state_q <= ST_INS_RD;
					end else begin
						count_q <= count_q + 1'b1;
						j_q     <= '0;
						total_q <= '0;
						have_q  <= 1'b0;
						state_q <= last_q ? ST_SW_RD : ST_IDLE;
					end
				end
				ST_SW_RD: begin
					state_q <= (j_q == count_q) ? ST_DONE : ST_SW_CMP;
				end
				ST_SW_CMP: begin
					// start at or below reach: count only past reach
					clip_q  <= have_q && (alu_res.neg || alu_res.zero);
					state_q <= ST_SW_CNT;
				end
				ST_SW_CNT: begin
					if (clip_q ? (!alu_res.neg && !alu_res.zero) : !alu_res.neg) begin
						total_q <= total_q + alu_res.diff[ACC_W-1:0]
							+ {{(ACC_W-1){1'b0}}, ~clip_q};
					end
					if (!clip_q || (!alu_res.neg && !alu_res.zero)) begin
						reach_q <= rd_data.hi;
					end
					have_q  <= 1'b1;
					j_q     <= j_q + 1'b1;
					state_q <= ST_SW_RD;
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						covered_q   <= total_q[ACC_W-1] ? TOTAL_MAX : total_q[TOTAL_W-1:0];
						overflow_q  <= ovf_q;
						count_q     <= '0;
						ovf_q       <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_SEGMENTS))
		else $error("segment count above capacity");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result posted outside the done state");

	a_sweep_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SW_CMP || state_q == ST_SW_CNT) |-> (j_q < count_q))
		else $error("sweep index past stored segments");

	a_ins_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INS_CS || state_q == ST_INS_CE)
		|-> (k_q != '0 && CW'(k_q) <= count_q))
		else $error("insertion slot out of range");
`endif

endmodule

`default_nettype wire
